// ===== hw/rtl/missing_sample_gap_interpolator_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef MISSING_SAMPLE_GAP_INTERPOLATOR_CORE_ASSERT_SVH
`define MISSING_SAMPLE_GAP_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define MGI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgi assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define MGI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgi assertion failed");

`endif

// ===== hw/rtl/mgi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mgi_pkg;

    localparam int MAX_GAP_DEF     = 63;
    localparam int VALUE_WIDTH_DEF = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/missing_sample_gap_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Linear gap fill over one column of signed Q16.16 samples.
// Input channel (in_valid/in_ready) takes one sample with its missing flag and
// the column_end mark. Output channel (out_valid/out_ready) gives the results:
// valid samples pass through, held-back missing samples come out just before
// the sample that closes their gap, interpolated between the two anchors.
// Leading gaps copy the next value, trailing gaps copy the last one, a column
// without any valid sample gives still_missing entries with value 0.
// A missing sample that only extends the gap is counted in the idle state; one
// that would pass MAX_GAP flushes the gap and itself, flagged gap_overflow.
// Else the item is prepared; held or copied entries go straight to the output
// load, interpolated ones through one multiply, 32 steps (VALUE_WIDTH steps)
// of the shared restoring divider, one sign fix and one output load.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next item is taken while it waits there.
// A stalled receiver (out_ready low) freezes the output register and holds
// the sequencer at its next load. Reset clears the anchor and the pending gap
// and empties the output register; no clearing pass is needed.
module missing_sample_gap_interpolator_core #(
    parameter int MAX_GAP     = mgi_pkg::MAX_GAP_DEF,
    parameter int VALUE_WIDTH = mgi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
    input  wire logic                          sample_missing,
    input  wire logic                          column_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0]      filled_value,
    output logic                               still_missing,
    output logic                               gap_overflow,
    output logic                               last_of_run
);
    import mgi_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int GAP_W  = $clog2(MAX_GAP + 1);
    localparam int DIV_W  = $clog2(MAX_GAP + 2);
    localparam int CNT_W  = (VW > 1) ? $clog2(VW) : 1;
    localparam int PROD_W = VW + GAP_W;

    state_t state_reg, state_next;

    // Column state.
    logic signed [VW-1:0] anchor_reg, anchor_next;
    logic                 anchor_valid_reg, anchor_valid_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;

    // Item being worked on.
    logic signed [VW-1:0] val_reg, val_next;
    logic                 miss_reg, miss_next;
    logic                 end_reg, end_next;
    logic [GAP_W-1:0]     n_reg, n_next;
    logic [GAP_W-1:0]     idx_reg, idx_next;

    // Shared multiply/divide unit.
    logic [VW-1:0]        abs_reg, abs_next;
    logic                 neg_reg, neg_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [VW-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]     bcnt_reg, bcnt_next;
    logic signed [VW:0]   step_reg, step_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] fv_reg, fv_next;
    logic                 sm_reg, sm_next;
    logic                 ovf_reg, ovf_next;
    logic                 last_reg, last_next;

    logic                 in_acc;
    logic                 extend_gap;
    logic                 out_free;
    logic                 interp_ok;
    logic [GAP_W-1:0]     idx_p1;
    logic                 idx_p1_lt_n;
    logic signed [VW:0]   diff;
    logic [PROD_W-1:0]    prod;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_W:0]       trial;
    logic                 take;
    logic signed [VW:0]   interp_sum;
    logic signed [VW-1:0] emit_value;
    logic                 emit_missing;
    logic                 emit_ovf;
    logic                 emit_last;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_acc        = in_valid && in_ready;
    assign extend_gap    = sample_missing && !column_end && (gap_reg < GAP_W'(MAX_GAP));
    assign out_free      = !out_valid_reg || out_ready;
    assign interp_ok     = !miss_reg && anchor_valid_reg;
    assign idx_p1        = idx_reg + GAP_W'(1);
    assign idx_p1_lt_n   = (idx_p1 < n_reg);

    assign diff     = {val_reg[VW-1], val_reg} - {anchor_reg[VW-1], anchor_reg};
    assign prod     = PROD_W'(abs_reg) * PROD_W'(idx_p1);
    assign divisor  = DIV_W'(n_reg) + DIV_W'(1);
    assign trial    = {rem_reg, quo_reg[VW-1]};
    assign take     = (trial >= {1'b0, divisor});
    assign interp_sum = {anchor_reg[VW-1], anchor_reg} + step_reg;

    // Result for the entry at idx_reg.
    always_comb
    begin
        emit_last    = (idx_reg == n_reg);
        emit_ovf     = miss_reg && !end_reg;
        emit_missing = miss_reg && !anchor_valid_reg;
        if (miss_reg)
        begin
            emit_value = anchor_valid_reg ? anchor_reg : '0;
        end
        else if (!emit_last && anchor_valid_reg)
        begin
            emit_value = interp_sum[VW-1:0];
        end
        else
        begin
            emit_value = val_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !extend_gap)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = (interp_ok && (idx_reg < n_reg)) ? ST_MUL : ST_EMIT;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bcnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (interp_ok && idx_p1_lt_n)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        anchor_next       = anchor_reg;
        anchor_valid_next = anchor_valid_reg;
        gap_next          = gap_reg;
        val_next          = val_reg;
        miss_next         = miss_reg;
        end_next          = end_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        abs_next          = abs_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        bcnt_next         = bcnt_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        fv_next           = fv_reg;
        sm_next           = sm_reg;
        ovf_next          = ovf_reg;
        last_next         = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (extend_gap)
                    begin
                        gap_next = gap_reg + GAP_W'(1);
                    end
                    else
                    begin
                        // Latch the item; the gap so far becomes its entry count.
                        val_next  = sample_value;
                        miss_next = sample_missing;
                        end_next  = column_end;
                        n_next    = gap_reg;
                        idx_next  = '0;
                    end
                end
            end
            ST_PREP:
            begin
                neg_next = diff[VW];
                abs_next = diff[VW] ? VW'(-diff) : VW'(diff);
            end
            ST_MUL:
            begin
                // Quotient fits VW bits, so the top bits start as the remainder.
                rem_next  = DIV_W'(prod[PROD_W-1:VW]);
                quo_next  = prod[VW-1:0];
                bcnt_next = CNT_W'(VW - 1);
            end
            ST_DIV:
            begin
                rem_next  = take ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
                quo_next  = {quo_reg[VW-2:0], take};
                bcnt_next = bcnt_reg - CNT_W'(1);
            end
            ST_SIGN:
            begin
                step_next = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fv_next        = emit_value;
                    sm_next        = emit_missing;
                    ovf_next       = emit_ovf;
                    last_next      = emit_last;
                    idx_next       = idx_p1;
                    if (emit_last)
                    begin
                        gap_next = '0;
                        if (!miss_reg)
                        begin
                            anchor_next       = val_reg;
                            anchor_valid_next = 1'b1;
                        end
                        // Start the next column fresh.
                        if (end_reg)
                        begin
                            anchor_next       = '0;
                            anchor_valid_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            anchor_reg       <= '0;
            anchor_valid_reg <= 1'b0;
            gap_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            anchor_reg       <= anchor_next;
            anchor_valid_reg <= anchor_valid_next;
            gap_reg          <= gap_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        miss_reg <= miss_next;
        end_reg  <= end_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        abs_reg  <= abs_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bcnt_reg <= bcnt_next;
        step_reg <= step_next;
        fv_reg   <= fv_next;
        sm_reg   <= sm_next;
        ovf_reg  <= ovf_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign filled_value  = fv_reg;
    assign still_missing = sm_reg;
    assign gap_overflow  = ovf_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mgi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "missing_sample_gap_interpolator_core_assert.svh"

module mgi_checker #(
    parameter int VALUE_WIDTH = mgi_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          sample_missing,
    input wire logic                          column_end,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [VALUE_WIDTH-1:0] filled_value,
    input wire logic                          still_missing
);

    logic item_has_results;

    assign item_has_results = in_valid && in_ready && (!sample_missing || column_end);

    // Stalled result holds.
    `MGI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filled_value))

    // An entry without anchor carries value zero.
    `MGI_ASSERT_NOW(a_missing_zero, out_valid && still_missing, filled_value == '0)

    // A valid or column-ending item closes the input in the cycle after it is taken.
    `MGI_ASSERT_NEXT(a_busy_after_item, item_has_results, !in_ready)

    // With the output empty, no result appears in the cycle right after an item is taken.
    `MGI_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind missing_sample_gap_interpolator_core mgi_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_mgi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_missing (sample_missing),
    .column_end     (column_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filled_value   (filled_value),
    .still_missing  (still_missing)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Take the block's widths from the package so the predictor matches the ports.
    localparam int VW             = mgi_pkg::VALUE_WIDTH_DEF;
    localparam int GAP_LIMIT      = mgi_pkg::MAX_GAP_DEF;
    localparam int ITEM_TARGET    = 430;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int LONG_HOLD      = 400;

    // One result item as the block presents it on the output channel.
    typedef struct packed {
        logic [VW-1:0] value;
        logic          still;
        logic          ovf;
        logic          last;
    } fill_result_t;

    // One row of the directed table. Rows marked typed cause exactly one
    // result whose value and still_missing flag are written in here.
    typedef struct packed {
        logic [VW-1:0] value;
        logic          missing;
        logic          col_end;
        logic          typed;
        logic [VW-1:0] typed_value;
        logic          typed_still;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Single-sample columns: extremes pass straight through.
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        // Column with nothing valid: value is forced to zero; then two single-sample columns.
        '{32'hDEAD_BEEF, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
        // Leading gap copies the first valid value.
        '{32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
        // Interpolate down to the most negative value.
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
        // Full swing from minimum to maximum over one missing entry.
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
        // Trailing gap at column end holds the last anchor.
        '{32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0001, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        // Column of two missing samples: both stay missing.
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        // Odd difference: the midpoint truncates.
        '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0003, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
        // Negative difference smaller than the step count truncates toward zero.
        '{32'h0000_0005, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0004, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic signed [VW-1:0] sample_value   = '0;
    logic                 sample_missing = 1'b0;
    logic                 column_end     = 1'b0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic signed [VW-1:0] filled_value;
    logic                 still_missing;
    logic                 gap_overflow;
    logic                 last_of_run;

    // Predictor state: last anchor, whether one exists, and held-back gap length.
    logic signed [VW-1:0] anchor_q;
    bit                   anchor_seen;
    int                   held_gap;

    fill_result_t expected_fills [$];
    fill_result_t step_fills [$];
    int           err_count;
    int           results_checked;
    int           items_sent;
    int           burst_left;

    always #5 clk = ~clk;

    missing_sample_gap_interpolator_core #(
        .MAX_GAP     (GAP_LIMIT),
        .VALUE_WIDTH (VW)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .column_end     (column_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filled_value   (filled_value),
        .still_missing  (still_missing),
        .gap_overflow   (gap_overflow),
        .last_of_run    (last_of_run)
    );

    // Append count copies of the anchor, or missing entries without one.
    function automatic void hold_anchor(input int count, input bit ovf);
        fill_result_t r;
        for (int i = 0; i < count; i++)
        begin
            r.value = anchor_seen ? anchor_q : '0;
            r.still = !anchor_seen;
            r.ovf   = ovf;
            r.last  = 1'b0;
            step_fills = {step_fills, r};
        end
    endfunction

    // Work out the results one accepted item causes into step_fills and
    // advance the predictor state.
    function automatic void predict_fills(input logic signed [VW-1:0] value,
                                          input bit missing, input bit col_end);
        fill_result_t r;
        longint       diff;
        longint       sum;
        step_fills.delete();
        if (missing)
        begin
            if (col_end)
                hold_anchor(held_gap + 1, 1'b0);
            else if (held_gap < GAP_LIMIT)
            begin
                held_gap++;
                return;
            end
            else
            begin
                hold_anchor(held_gap + 1, 1'b1);
                held_gap = 0;
            end
        end
        else
        begin
            for (int i = 0; i < held_gap; i++)
            begin
                if (anchor_seen)
                begin
                    diff = longint'(value) - longint'(anchor_q);
                    sum  = longint'(anchor_q) + (diff * longint'(i + 1)) / longint'(held_gap + 1);
                    r.value = sum[VW-1:0];
                end
                else
                    r.value = value;
                r.still = 1'b0;
                r.ovf   = 1'b0;
                r.last  = 1'b0;
                step_fills = {step_fills, r};
            end
            r.value = value;
            r.still = 1'b0;
            r.ovf   = 1'b0;
            r.last  = 1'b0;
            step_fills = {step_fills, r};
            anchor_q    = value;
            anchor_seen = 1'b1;
            held_gap    = 0;
        end
        if (col_end)
        begin
            anchor_q    = '0;
            anchor_seen = 1'b0;
            held_gap    = 0;
        end
        step_fills[step_fills.size() - 1].last = 1'b1;
    endfunction

    // Mix extremes, small signed values, scaled values and full random words.
    function automatic logic [VW-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            3: return 32'($signed($urandom()) >>> $urandom_range(4, 24));
            default: return $urandom();
        endcase
    endfunction

    // Offer one item: open a new burst with a random gap when the old one is
    // used up, hold the item until it is taken, then predict its results.
    task automatic offer_item(input logic [VW-1:0] value, input bit missing,
                              input bit col_end, input bit typed,
                              input logic [VW-1:0] typed_value, input bit typed_still);
        int           idle_gap;
        fill_result_t r;
        if (burst_left == 0)
        begin
            idle_gap   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (idle_gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (idle_gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        sample_value   <= value;
        sample_missing <= missing;
        column_end     <= col_end;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_fills(value, missing, col_end);
        if (typed)
        begin
            // Check against the value written in the table, not the predictor.
            r.value = typed_value;
            r.still = typed_still;
            r.ovf   = 1'b0;
            r.last  = 1'b1;
            expected_fills = {expected_fills, r};
        end
        else
            foreach (step_fills[i])
                expected_fills = {expected_fills, step_fills[i]};
        items_sent++;
    endtask

    // Send one column. miss_pct_in and run_in below zero mean pick at random;
    // a run is a stretch of missing samples placed after at least one sample.
    task automatic send_column(input int miss_pct_in, input int run_in);
        int n_samples;
        int miss_pct;
        int run_len;
        int run_at;
        miss_pct = miss_pct_in;
        if (miss_pct < 0)
            case ($urandom_range(0, 3))
                0: miss_pct = 0;
                1: miss_pct = 25;
                2: miss_pct = 50;
                default: miss_pct = 90;
            endcase
        run_len = run_in;
        if (run_len < 0)
        begin
            run_len = 0;
            if ($urandom_range(0, 11) == 0)
                case ($urandom_range(0, 4))
                    0: run_len = GAP_LIMIT - 1;
                    1: run_len = GAP_LIMIT;
                    2: run_len = GAP_LIMIT + 1;
                    3: run_len = GAP_LIMIT + 2;
                    default: run_len = $urandom_range(GAP_LIMIT + 3, 2 * GAP_LIMIT + 14);
                endcase
        end
        n_samples = $urandom_range(run_len > 0 ? 2 : 1, 12);
        run_at    = $urandom_range(run_len > 0 ? 1 : 0, n_samples - 1);
        for (int idx = 0; idx < n_samples; idx++)
        begin
            if (idx == run_at)
                repeat (run_len)
                    offer_item(random_sample(), 1'b1, 1'b0, 1'b0, '0, 1'b0);
            offer_item(random_sample(), $urandom_range(0, 99) < miss_pct,
                       idx == n_samples - 1, 1'b0, '0, 1'b0);
        end
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        fill_result_t got;
        fill_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{filled_value, still_missing, gap_overflow, last_of_run};
            if (expected_fills.size() == 0)
            begin
                $display("%0t: unexpected result value=%h still=%b ovf=%b last=%b",
                         $time, got.value, got.still, got.ovf, got.last);
                err_count++;
            end
            else
            begin
                want = expected_fills.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch, expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             $time, want.value, want.still, want.ovf, want.last,
                             got.value, got.still, got.ovf, got.last);
                    err_count++;
                end
            end
            results_checked++;
        end
    end

    // Receiver: stall on rotating 8-bit ready patterns, with one long hold
    // so the block fills up and drops in_ready while items keep coming.
    initial
    begin : receiver
        int         mode_left;
        int         phase;
        bit         long_hold_done;
        logic [7:0] pattern;
        mode_left      = 0;
        phase          = 0;
        long_hold_done = 1'b0;
        pattern        = 8'hFF;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_checked >= 60)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: pattern = 8'hFF;
                    2: pattern = 8'($urandom()) | 8'h01;
                    default: pattern = 8'h01 << $urandom_range(0, 7);
                endcase
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            out_ready <= pattern[phase];
            phase = (phase + 1) % 8;
        end
    end

    // Watchdog: end the run when neither channel moves an item for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("missing_sample_gap_interpolator_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int col;
        anchor_q        = '0;
        anchor_seen     = 1'b0;
        held_gap        = 0;
        err_count       = 0;
        results_checked = 0;
        items_sent      = 0;
        burst_left      = 0;
        col             = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int row = 0; row < DIRECTED_ROWS; row++)
            offer_item(DIRECTED[row].value, DIRECTED[row].missing, DIRECTED[row].col_end,
                       DIRECTED[row].typed, DIRECTED[row].typed_value,
                       DIRECTED[row].typed_still);

        // Open with overflow flushes with and without an anchor and a
        // longest interpolated gap, then random columns.
        while (items_sent < ITEM_TARGET)
        begin
            case (col)
                0: send_column(100, GAP_LIMIT + 1);
                1: send_column(0, GAP_LIMIT + 2);
                2: send_column(0, GAP_LIMIT);
                default: send_column(-1, -1);
            endcase
            col++;
        end
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (expected_fills.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("missing_sample_gap_interpolator_core regression: pass");
        else
            $display("missing_sample_gap_interpolator_core regression: fail");
        $finish;
    end

endmodule
